// ===== sv/gpm_pkg.sv =====
// gpm_pkg: constants, codes and types shared by the glob pattern matcher
// no dependencies
`timescale 1ns / 1ps

package gpm_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int SUBJECT_DEPTH = 256;
  localparam int PAW = $clog2(PATTERN_DEPTH);
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int SAW = $clog2(SUBJECT_DEPTH);
  localparam int SCW = $clog2(SUBJECT_DEPTH + 1);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_RULE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPES_OFF = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAT  = 2'd0,
    KIND_SUBJ = 2'd1,
    KIND_EVAL = 2'd2,
    KIND_CLR  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_PAT,
    DP_LOAD_SUBJ,
    DP_CLR_PAT,
    DP_START,
    DP_LEAD,
    DP_STAR,
    DP_STEP,
    DP_PA_INC,
    DP_BANG,
    DP_SCAN_HIT,
    DP_MEMB,
    DP_SET_STEP,
    DP_BACK,
    DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic pat_end;
    logic subj_end;
    logic is_star;
    logic is_qmark;
    logic is_lbrack;
    logic is_esc;
    logic is_rbrack;
    logic lit_eq;
    logic star_last;
    logic lead_hit;
    logic set_pos_end;
    logic invert;
    logic memb_last;
    logic memb_hit;
    logic star_ok;
    logic ovf;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_MAIN,
    ST_ESC,
    ST_BANG,
    ST_SCAN,
    ST_MEMB,
    ST_FIN
  } state_e;

endpackage

// ===== sv/gpm_if.sv =====
// gpm_if: valid/ready channel interfaces for items in and results out
// depends on nothing
`timescale 1ns / 1ps

interface gpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  modport source (output valid, kind, char_code, input ready);
  modport sink (input valid, kind, char_code, output ready);
endinterface

interface gpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;
  modport source (output valid, matched, overflowed, input ready);
  modport sink (input valid, matched, overflowed, output ready);
endinterface

// ===== sv/gpm_ram.sv =====
// gpm_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module gpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/gpm_datapath.sv =====
// gpm_datapath: pattern and subject stores, counters, match pointers and set scan
// depends on gpm_pkg and gpm_ram
`timescale 1ns / 1ps

module gpm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gpm_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic                         cfg_data_i,
  input  logic [7:0]                   char_code_i,
  input  gpm_pkg::dp_cmd_t             cmd_i,
  output gpm_pkg::dp_status_t          status_o
);
  import gpm_pkg::*;

  logic [PCW-1:0] pcount_q, pcount_d, pa_q, pa_d, pa_inc, pos;
  logic [PCW-1:0] star_p_q, star_p_d, first_q, first_d, close_q, close_d;
  logic [SCW-1:0] scount_q, scount_d, si_q, si_d, star_s_q, star_s_d;
  logic ovf_q, ovf_d, period_q, esc_off_q;
  logic have_star_q, have_star_d, lead_q, lead_d, invert_q, invert_d, hit_q, hit_d;
  logic [7:0] prev_q, prev_d, prev2_q, prev2_d, c, s, lo, hi;
  logic [1:0] cnt_q, cnt_d;
  logic pat_full, subj_full, pat_we, subj_we, bang, in_rng;

  gpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pcount_q[PAW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (pa_d[PAW-1:0]),
    .rdata_o (c)
  );

  gpm_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_subj_ram (
    .clk_i   (clk_i),
    .we_i    (subj_we),
    .waddr_i (scount_q[SAW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (si_d[SAW-1:0]),
    .rdata_o (s)
  );

  assign pat_full  = (pcount_q == PCW'(PATTERN_DEPTH));
  assign subj_full = (scount_q == SCW'(SUBJECT_DEPTH));
  assign pat_we    = (cmd_i.op == DP_LOAD_PAT) && !pat_full;
  assign subj_we   = (cmd_i.op == DP_LOAD_SUBJ) && !subj_full;

  // the read address is the next pointer, so read data always belongs to pa_q / si_q
  assign pa_inc = pa_q + 1'b1;
  assign bang   = (pa_q < pcount_q) && (c == CH_BANG);
  assign pos    = bang ? pa_inc : pa_q;
  assign lo     = (prev2_q < c) ? prev2_q : c;
  assign hi     = (prev2_q < c) ? c : prev2_q;
  assign in_rng = (s > lo) && (s < hi);

  always_comb begin
    status_o.pat_end     = (pa_q >= pcount_q);
    status_o.subj_end    = (si_q >= scount_q);
    status_o.is_star     = (c == CH_STAR);
    status_o.is_qmark    = (c == CH_QMARK);
    status_o.is_lbrack   = (c == CH_LBRACK);
    status_o.is_esc      = (c == CH_BSLASH) && !esc_off_q && (pa_inc < pcount_q);
    status_o.is_rbrack   = (c == CH_RBRACK);
    status_o.lit_eq      = (s == c);
    status_o.star_last   = (pa_inc >= pcount_q);
    status_o.lead_hit    = lead_q && (si_q == '0);
    status_o.set_pos_end = (pos >= pcount_q);
    status_o.invert      = invert_q;
    status_o.memb_last   = (pa_inc == close_q);
    // a dash that is neither first nor last in the set spans its neighbors
    status_o.memb_hit    = hit_q || (c == s) ||
                           ((cnt_q == 2'd2) && (prev_q == CH_DASH) && in_rng);
    status_o.star_ok     = have_star_q && (star_s_q < scount_q);
    status_o.ovf         = ovf_q;
  end

  always_comb begin
    pcount_d    = pcount_q;
    scount_d    = scount_q;
    ovf_d       = ovf_q;
    pa_d        = pa_q;
    si_d        = si_q;
    star_p_d    = star_p_q;
    star_s_d    = star_s_q;
    have_star_d = have_star_q;
    lead_d      = lead_q;
    invert_d    = invert_q;
    first_d     = first_q;
    close_d     = close_q;
    hit_d       = hit_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    prev2_d     = prev2_q;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_LOAD_PAT: begin
        if (pat_full) ovf_d = 1'b1;
        else pcount_d = pcount_q + 1'b1;
      end
      DP_LOAD_SUBJ: begin
        if (subj_full) ovf_d = 1'b1;
        else scount_d = scount_q + 1'b1;
      end
      DP_CLR_PAT: pcount_d = '0;
      DP_START: begin
        pa_d        = '0;
        si_d        = '0;
        have_star_d = 1'b0;
      end
      DP_LEAD: lead_d = period_q && (scount_q != '0) && (s == CH_DOT);
      DP_STAR: begin
        pa_d        = pa_inc;
        star_p_d    = pa_inc;
        star_s_d    = si_q;
        have_star_d = 1'b1;
      end
      DP_STEP: begin
        si_d = si_q + 1'b1;
        pa_d = pa_inc;
      end
      DP_PA_INC: pa_d = pa_inc;
      DP_BANG: begin
        invert_d = bang;
        first_d  = pos;
        pa_d     = pos + 1'b1;
      end
      DP_SCAN_HIT: begin
        close_d = pa_q;
        pa_d    = first_q;
        hit_d   = 1'b0;
        cnt_d   = 2'd0;
      end
      DP_MEMB: begin
        hit_d   = status_o.memb_hit;
        prev2_d = prev_q;
        prev_d  = c;
        cnt_d   = (cnt_q == 2'd2) ? cnt_q : cnt_q + 1'b1;
        pa_d    = pa_inc;
      end
      DP_SET_STEP: begin
        si_d = si_q + 1'b1;
        pa_d = close_q + 1'b1;
      end
      DP_BACK: begin
        star_s_d = star_s_q + 1'b1;
        si_d     = star_s_q + 1'b1;
        pa_d     = star_p_q;
      end
      DP_FINISH: begin
        ovf_d    = 1'b0;
        scount_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q  <= '0;
      scount_q  <= '0;
      ovf_q     <= 1'b0;
      period_q  <= 1'b0;
      esc_off_q <= 1'b0;
    end else begin
      pcount_q <= pcount_d;
      scount_q <= scount_d;
      ovf_q    <= ovf_d;
      if (cfg_we_i && (cfg_idx_i == REG_PERIOD_RULE)) period_q <= cfg_data_i;
      if (cfg_we_i && (cfg_idx_i == REG_ESCAPES_OFF)) esc_off_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q        <= pa_d;
    si_q        <= si_d;
    star_p_q    <= star_p_d;
    star_s_q    <= star_s_d;
    have_star_q <= have_star_d;
    lead_q      <= lead_d;
    invert_q    <= invert_d;
    first_q     <= first_d;
    close_q     <= close_d;
    hit_q       <= hit_d;
    cnt_q       <= cnt_d;
    prev_q      <= prev_d;
    prev2_q     <= prev2_d;
  end

endmodule

// ===== sv/gpm_ctrl.sv =====
// gpm_ctrl: sequencer of the matcher, handshakes and the result register
// depends on gpm_pkg
`timescale 1ns / 1ps

module gpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_kind_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_matched_o,
  output logic                out_overflowed_o,
  input  gpm_pkg::dp_status_t status_i,
  output gpm_pkg::dp_cmd_t    cmd_o
);
  import gpm_pkg::*;

  state_e state_q, state_d;
  logic   res_q, res_d;
  logic   out_valid_q, matched_q, ovf_out_q, slot_free;

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign out_matched_o    = matched_q;
  assign out_overflowed_o = ovf_out_q;
  assign slot_free        = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (kind_e'(in_kind_i) == KIND_EVAL)) state_d = ST_LEAD;
      end
      ST_LEAD: state_d = ST_MAIN;
      ST_MAIN: begin
        priority if (status_i.pat_end) begin
          if (status_i.subj_end) begin
            state_d = ST_FIN;
            res_d   = 1'b1;
          end else if (!status_i.star_ok) begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end
        end else if (status_i.is_star) begin
          if (status_i.lead_hit) begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end else if (status_i.star_last) begin
            state_d = ST_FIN;
            res_d   = 1'b1;
          end
        end else if (status_i.subj_end) begin
          if (!status_i.star_ok) begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end
        end else if (status_i.is_qmark) begin
          if (status_i.lead_hit) begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end
        end else if (status_i.is_lbrack) begin
          state_d = ST_BANG;
        end else if (status_i.is_esc) begin
          state_d = ST_ESC;
        end else begin
          if (!status_i.lit_eq && !status_i.star_ok) begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end
        end
      end
      ST_ESC: begin
        if (status_i.lit_eq || status_i.star_ok) begin
          state_d = ST_MAIN;
        end else begin
          state_d = ST_FIN;
          res_d   = 1'b0;
        end
      end
      ST_BANG: begin
        if (status_i.set_pos_end) begin
          state_d = ST_FIN;
          res_d   = 1'b0;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status_i.pat_end) begin
          state_d = ST_FIN;
          res_d   = 1'b0;
        end else if (status_i.is_rbrack) begin
          if (status_i.invert && status_i.lead_hit) begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end else begin
            state_d = ST_MEMB;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_MEMB: begin
        if (status_i.memb_last) begin
          if ((status_i.memb_hit != status_i.invert) || status_i.star_ok) begin
            state_d = ST_MAIN;
          end else begin
            state_d = ST_FIN;
            res_d   = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op = DP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_e'(in_kind_i))
            KIND_PAT:  cmd_o.op = DP_LOAD_PAT;
            KIND_SUBJ: cmd_o.op = DP_LOAD_SUBJ;
            KIND_EVAL: cmd_o.op = DP_START;
            KIND_CLR:  cmd_o.op = DP_CLR_PAT;
            default:   cmd_o.op = DP_NOP;
          endcase
        end
      end
      ST_LEAD: cmd_o.op = DP_LEAD;
      ST_MAIN: begin
        priority if (status_i.pat_end) begin
          if (!status_i.subj_end && status_i.star_ok) cmd_o.op = DP_BACK;
        end else if (status_i.is_star) begin
          if (!status_i.lead_hit && !status_i.star_last) cmd_o.op = DP_STAR;
        end else if (status_i.subj_end) begin
          if (status_i.star_ok) cmd_o.op = DP_BACK;
        end else if (status_i.is_qmark) begin
          if (!status_i.lead_hit) cmd_o.op = DP_STEP;
        end else if (status_i.is_lbrack || status_i.is_esc) begin
          cmd_o.op = DP_PA_INC;
        end else if (status_i.lit_eq) begin
          cmd_o.op = DP_STEP;
        end else if (status_i.star_ok) begin
          cmd_o.op = DP_BACK;
        end else begin
          cmd_o.op = DP_NOP;
        end
      end
      ST_ESC: begin
        if (status_i.lit_eq) cmd_o.op = DP_STEP;
        else if (status_i.star_ok) cmd_o.op = DP_BACK;
      end
      ST_BANG: begin
        if (!status_i.set_pos_end) cmd_o.op = DP_BANG;
      end
      ST_SCAN: begin
        priority if (status_i.pat_end) begin
          cmd_o.op = DP_NOP;
        end else if (status_i.is_rbrack) begin
          if (!(status_i.invert && status_i.lead_hit)) cmd_o.op = DP_SCAN_HIT;
        end else begin
          cmd_o.op = DP_PA_INC;
        end
      end
      ST_MEMB: begin
        if (!status_i.memb_last) cmd_o.op = DP_MEMB;
        else if (status_i.memb_hit != status_i.invert) cmd_o.op = DP_SET_STEP;
        else if (status_i.star_ok) cmd_o.op = DP_BACK;
      end
      ST_FIN: begin
        if (slot_free) cmd_o.op = DP_FINISH;
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if ((state_q == ST_FIN) && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && slot_free) begin
      matched_q <= res_q;
      ovf_out_q <= status_i.ovf;
    end
  end

endmodule

// ===== sv/glob_pattern_matcher.sv =====
// glob_pattern_matcher: top level, joins the sequencer and the datapath
// depends on gpm_pkg, gpm_if, gpm_ctrl and gpm_datapath
`timescale 1ns / 1ps

// Loads a glob pattern (up to 64 bytes) and a subject (up to 256 bytes) one byte per
// transaction, and on an evaluate transaction matches the whole subject against the
// pattern with '*', '?', bracket sets, escapes and the leading-period rule, giving one
// result transaction with matched and overflowed flags. Load and clear transactions
// give no result. An evaluate holds the input off through setup, each pattern step
// and each backtrack to the last star; a bracket set first looks for '!', then scans
// the bytes up to the closing ']', then tests each set byte for membership, so the
// worst case grows with pattern length times subject length. Each step reads one
// byte from each store through its registered read port. The result sits in an
// output register, so further loads are taken while it waits; the next evaluate
// finishes only once it is taken. There is no clearing pass after reset.
module glob_pattern_matcher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gpm_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic                         cfg_data_i,
  gpm_in_if.sink                       in_ch,
  gpm_out_if.source                    out_ch
);
  import gpm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gpm_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_kind_i        (in_ch.kind),
    .in_ready_o       (in_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_matched_o    (out_ch.matched),
    .out_overflowed_o (out_ch.overflowed),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  gpm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .char_code_i (in_ch.char_code),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`ifndef SYNTHESIS
  // an evaluate transaction holds the input off while the match runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && (in_ch.kind == KIND_EVAL)) |=> !in_ch.ready)
    else $error("input still ready after evaluate");

  // a result only appears after a match run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result without a match run");

  // store load commands are only issued for an accepted input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_LOAD_PAT || cmd.op == DP_LOAD_SUBJ) |-> (in_ch.valid && in_ch.ready))
    else $error("store written without an accepted transaction");
`endif

endmodule

// ===== bench/gpm_scoreboard.sv =====
// gpm_scoreboard: golden glob matcher and expected-result queue for the testbench
// depends on gpm_pkg
`timescale 1ns / 1ps

class gpm_scoreboard;
  logic [7:0] pat_bytes[gpm_pkg::PATTERN_DEPTH];
  logic [7:0] subj_bytes[gpm_pkg::SUBJECT_DEPTH];
  int unsigned pat_len;
  int unsigned subj_len;
  bit ovf_mark;
  bit period_rule;
  bit escapes_off;
  bit exp_matched[$];
  bit exp_ovf[$];
  int unsigned errors;

  function new();
    pat_len = 0;
    subj_len = 0;
    ovf_mark = 0;
    period_rule = 0;
    escapes_off = 0;
    errors = 0;
  endfunction

  function bit in_set(logic [7:0] b, int unsigned first, int unsigned len);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] t;
    for (int unsigned k = 0; k < len; k++) begin
      if (k != 0 && k + 1 != len && pat_bytes[first+k] == gpm_pkg::CH_DASH) begin
        lo = pat_bytes[first+k-1];
        hi = pat_bytes[first+k+1];
        if (lo > hi) begin
          t = lo;
          lo = hi;
          hi = t;
        end
        if (b > lo && b < hi) return 1;
      end
      if (pat_bytes[first+k] == b) return 1;
    end
    return 0;
  endfunction

  function bit glob_match();
    int unsigned pi, si, star_p, star_s, pos, first, close;
    bit have_star, lead_dot, ok, inv;
    logic [7:0] c;
    logic [7:0] lit;
    pi = 0;
    si = 0;
    star_p = 0;
    star_s = 0;
    have_star = 0;
    lead_dot = period_rule && subj_len > 0 && subj_bytes[0] == gpm_pkg::CH_DOT;
    forever begin
      ok = 0;
      if (pi >= pat_len) begin
        if (si >= subj_len) return 1;
      end else begin
        c = pat_bytes[pi];
        if (c == gpm_pkg::CH_STAR) begin
          if (si == 0 && lead_dot) return 0;
          pi++;
          if (pi >= pat_len) return 1;
          have_star = 1;
          star_p = pi;
          star_s = si;
          continue;
        end else if (si >= subj_len) begin
          ok = 0;
        end else if (c == gpm_pkg::CH_QMARK) begin
          if (si == 0 && lead_dot) return 0;
          si++;
          pi++;
          ok = 1;
        end else if (c == gpm_pkg::CH_LBRACK) begin
          pos = pi + 1;
          inv = 0;
          if (pos < pat_len && pat_bytes[pos] == gpm_pkg::CH_BANG) begin
            inv = 1;
            pos++;
          end
          if (pos >= pat_len) return 0;
          first = pos;
          close = pos + 1;
          while (close < pat_len && pat_bytes[close] != gpm_pkg::CH_RBRACK) close++;
          if (close >= pat_len) return 0;
          if (inv && si == 0 && lead_dot) return 0;
          ok = in_set(subj_bytes[si], first, close - first) != inv;
          si++;
          pi = close + 1;
        end else begin
          lit = c;
          if (c == gpm_pkg::CH_BSLASH && !escapes_off && pi + 1 < pat_len) begin
            pi++;
            lit = pat_bytes[pi];
          end
          ok = subj_bytes[si] == lit;
          si++;
          pi++;
        end
      end
      if (!ok) begin
        if (have_star && star_s < subj_len) begin
          star_s++;
          si = star_s;
          pi = star_p;
        end else begin
          return 0;
        end
      end
    end
  endfunction

  function void note_input(gpm_pkg::kind_e kind, logic [7:0] ch);
    case (kind)
      gpm_pkg::KIND_PAT: begin
        if (pat_len < gpm_pkg::PATTERN_DEPTH) pat_bytes[pat_len++] = ch;
        else ovf_mark = 1;
      end
      gpm_pkg::KIND_SUBJ: begin
        if (subj_len < gpm_pkg::SUBJECT_DEPTH) subj_bytes[subj_len++] = ch;
        else ovf_mark = 1;
      end
      gpm_pkg::KIND_EVAL: begin
        exp_matched.push_back(glob_match());
        exp_ovf.push_back(ovf_mark);
        ovf_mark = 0;
        subj_len = 0;
      end
      default: pat_len = 0;
    endcase
  endfunction

  function void check_result(logic matched, logic overflowed);
    bit em, eo;
    if (exp_matched.size() == 0) begin
      $error("unexpected result transaction");
      errors++;
      return;
    end
    em = exp_matched.pop_front();
    eo = exp_ovf.pop_front();
    if (matched !== em) begin
      $error("matched: expected %0d actual %0d", em, matched);
      errors++;
    end
    if (overflowed !== eo) begin
      $error("overflowed: expected %0d actual %0d", eo, overflowed);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return exp_matched.size();
  endfunction
endclass

// ===== bench/testbench.sv =====
// testbench: random and directed stimulus for glob_pattern_matcher
// depends on gpm_pkg, gpm_if, gpm_scoreboard and the rtl
`timescale 1ns / 1ps

module testbench;
  import gpm_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [REG_IDX_W-1:0] cfg_idx_i = REG_PERIOD_RULE;
  logic cfg_data_i = 0;

  gpm_in_if in_ch ();
  gpm_out_if out_ch ();

  glob_pattern_matcher u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  gpm_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.kind = KIND_CLR;
    in_ch.char_code = 0;
    out_ch.ready = 0;
  end

  // receiver: ready changes at falling edge, result checked at rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.matched, out_ch.overflowed);
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(kind_e kind, logic [7:0] ch);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 0;
      @(negedge clk_i);
    end
    in_ch.valid = 1;
    in_ch.kind = kind;
    in_ch.char_code = ch;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(kind, ch);
    @(negedge clk_i);
    in_ch.valid = 0;
  endtask

  task automatic send_str(kind_e kind, string s);
    foreach (s[i]) send_item(kind, s[i]);
  endtask

  task automatic drain_and_config(bit pr, bit eo);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= REG_PERIOD_RULE;
    cfg_data_i <= pr;
    @(negedge clk_i);
    cfg_idx_i <= REG_ESCAPES_OFF;
    cfg_data_i <= eo;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.period_rule = pr;
    sb.escapes_off = eo;
  endtask

  function automatic logic [7:0] glob_byte();
    case ($urandom_range(15))
      0, 1: return CH_STAR;
      2: return CH_QMARK;
      3: return CH_LBRACK;
      4: return CH_RBRACK;
      5: return CH_BANG;
      6: return CH_DASH;
      7: return CH_DOT;
      8: return CH_BSLASH;
      9: return 8'($urandom_range(255));
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  function automatic logic [7:0] subj_byte();
    case ($urandom_range(7))
      0: return CH_DOT;
      1: return 8'($urandom_range(255));
      2: return CH_DASH;
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  // one match: new pattern (sometimes kept), subject, evaluate
  task automatic random_case();
    int plen, slen;
    if ($urandom_range(3) != 0) begin
      send_item(KIND_CLR, 8'($urandom_range(255)));
      plen = $urandom_range(0, 8);
      for (int i = 0; i < plen; i++) send_item(KIND_PAT, glob_byte());
    end
    slen = $urandom_range(0, 8);
    for (int i = 0; i < slen; i++) send_item(KIND_SUBJ, subj_byte());
    send_item(KIND_EVAL, 8'($urandom_range(255)));
  endtask

  task automatic directed_case(string p, string s);
    send_item(KIND_CLR, 8'h00);
    send_str(KIND_PAT, p);
    send_str(KIND_SUBJ, s);
    send_item(KIND_EVAL, 8'hFF);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    directed_case("a*[]x-b]?\\*", ".");
    directed_case("*", "");
    directed_case("[z-a", "q");
    directed_case("[!.]*", ".x");
    directed_case("\\", "\\");
    drain_and_config(1, 1);
    directed_case("*x", ".x");
    directed_case("a\\b", "a\\b");

    // overflow of both stores, with extreme bytes
    send_item(KIND_CLR, 8'h00);
    for (int i = 0; i < PATTERN_DEPTH + 2; i++) send_item(KIND_PAT, CH_STAR);
    for (int i = 0; i < SUBJECT_DEPTH + 1; i++) send_item(KIND_SUBJ, 8'(i));
    send_item(KIND_EVAL, 8'h00);
    send_item(KIND_SUBJ, 8'hFF);
    send_item(KIND_EVAL, 8'h00);

    // long receiver hold-off while items keep flowing
    drain_and_config(0, 0);
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) random_case();

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_config(ph[0], ph[1]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int i = 0; i < 15; i++) random_case();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
